@@ hdl/dstre_pkg.sv @@
// Shared types, constants and calendar helpers for the DST rule evaluator.
// Has no dependencies; every other file refers to it by scoped names.
package dstre_pkg;

  // Field widths of one input word.
  localparam int RULE_W  = 2;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int HOUR_W  = 5;

  // Rule codes. The spare code behaves like no rule.
  localparam logic [RULE_W-1:0] RULE_NONE  = 2'd0;
  localparam logic [RULE_W-1:0] RULE_EU    = 2'd1;
  localparam logic [RULE_W-1:0] RULE_US    = 2'd2;
  localparam logic [RULE_W-1:0] RULE_SPARE = 2'd3;

  // Months that carry a transition.
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

  // Transition hours in UTC.
  localparam logic [HOUR_W-1:0] EU_HOUR     = 5'd1;
  localparam logic [HOUR_W-1:0] US_ON_HOUR  = 5'd7;
  localparam logic [HOUR_W-1:0] US_OFF_HOUR = 5'd6;

  // Century split: year / 100 as (year * 5243) >> 19, exact for 14-bit years.
  localparam int CENT_W     = 8;
  localparam int RECIP_W    = 13;
  localparam int PROD_W     = YEAR_W + RECIP_W;
  localparam int RECIP_SH   = 19;
  localparam logic [RECIP_W-1:0] CENT_RECIP = 13'd5243;
  localparam int YSUM_W     = 10;

  // Weekday offsets (0 = Sunday) relative to the year code for the days
  // the rules look at: March 31st, October 31st, and the first of March
  // and of November, which share one offset.
  localparam logic [2:0] WD_MAR31 = 3'd5;
  localparam logic [2:0] WD_OCT31 = 3'd2;
  localparam logic [2:0] WD_FIRST = 3'd3;

  // Fields that travel beside the year arithmetic.
  typedef struct packed {
    logic [RULE_W-1:0]  rule;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [HOUR_W-1:0]  hour;
  } item_t;

  // Remainder modulo 7 of a 10-bit value by folding octal digits (8 = 1 mod 7).
  function automatic logic [2:0] mod7(input logic [YSUM_W-1:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[9]) + 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  // Weekday of a fixed day given its offset and the year code.
  function automatic logic [2:0] wd_add(input logic [2:0] c, input logic [2:0] yc);
    logic [3:0] s;
    s = {1'b0, c} + {1'b0, yc};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // Last Sunday of a 31-day month whose last day has weekday offset c.
  function automatic logic [DAY_W-1:0] last_sunday(input logic [2:0] c, input logic [2:0] yc);
    logic [2:0] wd;
    wd = wd_add(c, yc);
    return 5'd31 - {2'b00, wd};
  endfunction

  // First Sunday of March or November.
  function automatic logic [DAY_W-1:0] first_sunday(input logic [2:0] yc);
    logic [2:0] wd;
    wd = wd_add(WD_FIRST, yc);
    return (wd == 3'd0) ? 5'd1 : (5'd8 - {2'b00, wd});
  endfunction

endpackage

@@ hdl/dstre_year_code.sv @@
// Three-stage pipeline that reduces a Gregorian year to its Zeller year term
// modulo 7. Depends on dstre_pkg.
module dstre_year_code (
  input  logic                          clk,
  input  logic [dstre_pkg::YEAR_W-1:0]  year,
  output logic [2:0]                    year_code
);

  logic [dstre_pkg::PROD_W-1:0]  prod;
  logic [dstre_pkg::CENT_W-1:0]  cent_s1;
  logic [dstre_pkg::YEAR_W-1:0]  year_s1;
  logic [dstre_pkg::YEAR_W-1:0]  hundreds;
  logic [dstre_pkg::YEAR_W-1:0]  rem_full;
  logic [6:0]                    yr2;
  logic [dstre_pkg::YSUM_W-1:0]  ysum;
  logic [dstre_pkg::YSUM_W-1:0]  ysum_s2;

  // Stage 1: century by reciprocal multiplication.
  assign prod = dstre_pkg::PROD_W'(year) * dstre_pkg::PROD_W'(dstre_pkg::CENT_RECIP);

  always_ff @(posedge clk) begin
    cent_s1 <= prod[dstre_pkg::RECIP_SH +: dstre_pkg::CENT_W];
    year_s1 <= year;
  end

  // Stage 2: two-digit year and the Zeller sum k + k/4 + j/4 + 5j.
  assign hundreds = dstre_pkg::YEAR_W'(cent_s1) * 14'd100;
  assign rem_full = year_s1 - hundreds;
  assign yr2      = rem_full[6:0];
  assign ysum     = dstre_pkg::YSUM_W'(yr2) + dstre_pkg::YSUM_W'(yr2[6:2])
                  + dstre_pkg::YSUM_W'(cent_s1[7:2])
                  + dstre_pkg::YSUM_W'(cent_s1) * 10'd5;

  always_ff @(posedge clk) begin
    ysum_s2 <= ysum;
  end

  // Stage 3: reduce modulo 7.
  always_ff @(posedge clk) begin
    year_code <= dstre_pkg::mod7(ysum_s2);
  end

endmodule

@@ hdl/dst_rule_evaluator_unit.sv @@
// Top level of the DST rule evaluator: input capture, side-field pipeline and
// the rule decision stage. Depends on dstre_pkg and dstre_year_code.
//
// The unit takes one query word in every clock cycle (busy is always low) and
// returns its answer on dst_on with a one-cycle done strobe; dst_on and done
// are registered together, so the answer is valid while done is high. The
// pipeline has four register stages: century split by a reciprocal multiply,
// the Zeller year sum, its modulo-7 reduction, and a final stage that finds the
// transition Sunday and compares day and hour. Results come out in input order
// and cannot be held off.
module dst_rule_evaluator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [dstre_pkg::RULE_W-1:0]   rule_code,
  input  logic [dstre_pkg::DAY_W-1:0]    day,
  input  logic [dstre_pkg::MONTH_W-1:0]  month,
  input  logic [dstre_pkg::YEAR_W-1:0]   year,
  input  logic [dstre_pkg::HOUR_W-1:0]   hour_utc,
  output logic                           done,
  output logic                           dst_on
);

  logic                 accept;
  logic [2:0]           valid;
  dstre_pkg::item_t     item_in;
  dstre_pkg::item_t     item_s1;
  dstre_pkg::item_t     item_s2;
  dstre_pkg::item_t     item_s3;
  logic [2:0]           year_code;
  logic [dstre_pkg::DAY_W-1:0] eu_mar_day;
  logic [dstre_pkg::DAY_W-1:0] eu_oct_day;
  logic [dstre_pkg::DAY_W-1:0] us_nov_day;
  logic [dstre_pkg::DAY_W-1:0] us_mar_day;
  logic                 active_next;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign item_in = '{rule: rule_code, day: day, month: month, hour: hour_utc};

  // Year arithmetic, three stages.
  dstre_year_code u_year (
    .clk       (clk),
    .year      (year),
    .year_code (year_code)
  );

  // Valid bits follow the words through the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[1:0], accept};
      done  <= valid[2];
    end
  end

  // Side fields ride beside the year pipeline.
  always_ff @(posedge clk) begin
    item_s1 <= item_in;
    item_s2 <= item_s1;
    item_s3 <= item_s2;
  end

  // Transition days for this year.
  assign eu_mar_day = dstre_pkg::last_sunday(dstre_pkg::WD_MAR31, year_code);
  assign eu_oct_day = dstre_pkg::last_sunday(dstre_pkg::WD_OCT31, year_code);
  assign us_nov_day = dstre_pkg::first_sunday(year_code);
  assign us_mar_day = us_nov_day + 5'd7;

  // Rule decision.
  always_comb begin
    active_next = 1'b0;
    if (item_s3.rule == dstre_pkg::RULE_EU) begin
      priority if (item_s3.month < dstre_pkg::MONTH_MAR
                   || item_s3.month > dstre_pkg::MONTH_OCT) begin
        active_next = 1'b0;
      end else if (item_s3.month == dstre_pkg::MONTH_MAR) begin
        active_next = (item_s3.day > eu_mar_day)
                   || (item_s3.day == eu_mar_day && item_s3.hour >= dstre_pkg::EU_HOUR);
      end else if (item_s3.month == dstre_pkg::MONTH_OCT) begin
        active_next = (item_s3.day < eu_oct_day)
                   || (item_s3.day == eu_oct_day && item_s3.hour < dstre_pkg::EU_HOUR);
      end else begin
        active_next = 1'b1;
      end
    end else if (item_s3.rule == dstre_pkg::RULE_US) begin
      priority if (item_s3.month < dstre_pkg::MONTH_MAR
                   || item_s3.month > dstre_pkg::MONTH_NOV) begin
        active_next = 1'b0;
      end else if (item_s3.month == dstre_pkg::MONTH_MAR) begin
        active_next = (item_s3.day > us_mar_day)
                   || (item_s3.day == us_mar_day && item_s3.hour >= dstre_pkg::US_ON_HOUR);
      end else if (item_s3.month == dstre_pkg::MONTH_NOV) begin
        active_next = (item_s3.day < us_nov_day)
                   || (item_s3.day == us_nov_day && item_s3.hour < dstre_pkg::US_OFF_HOUR);
      end else begin
        active_next = 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    dst_on <= active_next;
  end

endmodule

@@ hdl/dstre_checker.sv @@
// Port-level checker for dst_rule_evaluator_unit and the bind that attaches it.
// Depends on dstre_pkg.
module dstre_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [dstre_pkg::RULE_W-1:0]   rule_code,
  input logic [dstre_pkg::MONTH_W-1:0]  month,
  input logic                           done,
  input logic                           dst_on
);

  // Every accepted word yields a done strobe for its result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word produced no result after four cycles");

  // No result appears without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching accepted word");

  // Rule codes without a rule always answer inactive.
  a_no_rule: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (rule_code != dstre_pkg::RULE_EU)
     && (rule_code != dstre_pkg::RULE_US)) |-> ##4 (done && !dst_on))
    else $error("inactive rule code reported daylight saving");

  // Months before March are never in daylight saving.
  a_winter: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (month < dstre_pkg::MONTH_MAR)) |-> ##4 !dst_on)
    else $error("month before March reported daylight saving");

endmodule

bind dst_rule_evaluator_unit dstre_checker u_dstre_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .rule_code  (rule_code),
  .month      (month),
  .done       (done),
  .dst_on     (dst_on)
);
